[hdl/pls_pkg.sv]
// Shared types, codes and defaults for the peer link supervisor.
package pls_pkg;

  localparam int unsigned NodesDef   = 8;
  localparam int unsigned TimeW      = 32;
  localparam int unsigned IntvW      = 16;
  localparam int unsigned PeerW      = 3;
  localparam int unsigned CmdW       = 3;
  localparam int unsigned ActW       = 2;
  localparam int unsigned MaskW      = 8;
  localparam int unsigned MaxOut     = 8;
  localparam int unsigned CntW       = 3;
  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned CfgDataW   = 16;

  localparam logic [IntvW-1:0] TimeoutRst   = 16'd4500;
  localparam logic [IntvW-1:0] KeepaliveRst = 16'd2000;

  typedef enum logic [CmdW-1:0] {
    CMD_TICK  = 3'd0,
    CMD_HEARD = 3'd1,
    CMD_SENT  = 3'd2,
    CMD_WORK  = 3'd3,
    CMD_MODE  = 3'd4
  } cmd_e;

  typedef enum logic [ActW-1:0] {
    ACT_NONE     = 2'd0,
    ACT_KEEP     = 2'd1,
    ACT_KEEP_ACK = 2'd2,
    ACT_UNLINK   = 2'd3
  } action_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_SELF      = 2'd0,
    CFG_TIMEOUT   = 2'd1,
    CFG_KEEPALIVE = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_AGE,
    S_HEARD,
    S_SENT_JUDGE_PREP
  } state_e;

  // compare flags from the shared delta unit
  typedef struct packed {
    logic gt_to;
    logic lt_to;
    logic gt_ka;
  } cmp_t;

endpackage

[hdl/pls_delta_unit.sv]
// Shared wrapping time delta with compares against timeout and keepalive.
module pls_delta_unit (
  input  logic [pls_pkg::TimeW-1:0] now_i,
  input  logic [pls_pkg::TimeW-1:0] base_i,
  input  logic [pls_pkg::IntvW-1:0] timeout_i,
  input  logic [pls_pkg::IntvW-1:0] keepalive_i,
  output pls_pkg::cmp_t             cmp_o
);
  import pls_pkg::*;

  logic [TimeW-1:0] diff;
  logic [TimeW-1:0] to_ext;
  logic [TimeW-1:0] ka_ext;

  assign diff   = now_i - base_i;
  assign to_ext = TimeW'(timeout_i);
  assign ka_ext = TimeW'(keepalive_i);

  assign cmp_o.gt_to = diff > to_ext;
  assign cmp_o.lt_to = diff < to_ext;
  assign cmp_o.gt_ka = diff > ka_ext;

endmodule

[hdl/peer_link_supervisor_core.sv]
// Top level of the peer link supervisor: peer table, tick sequencer, result port.
//
// A command other than a tick updates the table in the cycle it is taken and
// shows its single result in the next cycle; busy_o stays low, so commands may
// follow back to back. A tick raises busy_o and visits the peers in index
// order, skipping this node. One subtract-and-compare unit is shared by all
// time checks: the tick first checks the startup age, then for each visited
// peer takes the heard delta, the sent delta and the decision in turn, and
// shows one result per visited peer. busy_o falls as the last result appears,
// and a new request may be taken in that cycle. Results are shown for one cycle
// under result_valid_o and cannot be held off. Configuration writes are
// taken whenever busy_o is low and no request is offered on start_i.
module peer_link_supervisor_core #(
  parameter int unsigned NODES = pls_pkg::NodesDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  output logic                         busy_o,
  input  logic [pls_pkg::CmdW-1:0]     cmd_i,
  input  logic [pls_pkg::TimeW-1:0]    now_ms_i,
  input  logic [pls_pkg::PeerW-1:0]    peer_i,
  input  logic                         flag_value_i,
  input  logic                         main_role_i,
  input  logic                         restart_origin_i,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [pls_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [pls_pkg::CfgDataW-1:0] cfg_data_i,
  output logic                         result_valid_o,
  output logic [pls_pkg::PeerW-1:0]    peer_out_o,
  output logic [pls_pkg::ActW-1:0]     action_o,
  output logic [pls_pkg::MaskW-1:0]    linked_mask_o,
  output logic                         last_o
);
  import pls_pkg::*;

  localparam int unsigned IW = $clog2(NODES);
  localparam int unsigned CW = IW + 2;

  // configuration
  logic [PeerW-1:0] self_q;
  logic [IntvW-1:0] to_q;
  logic [IntvW-1:0] ka_q;

  // peer table and local mode
  logic [NODES-1:0] linked_q;
  logic [NODES-1:0] working_q;
  logic [TimeW-1:0] heard_q [NODES];
  logic [TimeW-1:0] sent_q  [NODES];
  logic [TimeW-1:0] origin_q;
  logic             local_work_q;
  logic             is_main_q;

  // sequencer
  state_e           state_q, state_d;
  logic [IW-1:0]    idx_q;
  logic [CntW-1:0]  cnt_q;
  logic [TimeW-1:0] now_q;
  logic             a_gt_to_q, a_lt_to_q;
  logic             h_gt_to_q, h_gt_ka_q;
  logic             s_gt_ka_q;
  logic             judge_phase_q;

  // result register
  logic             res_valid_q;
  logic [PeerW-1:0] res_peer_q;
  action_e          res_act_q;
  logic             res_last_q;

  logic             accept;
  logic             peer_ok;
  logic [CW-1:0]    peer_ext;
  logic [IW-1:0]    peer_ix;
  logic [CW-1:0]    self_ext;
  logic [CW-1:0]    cand1, cand2, nxt;
  logic             tick_last;
  logic [IW-1:0]    first_ix;
  logic [TimeW-1:0] unit_base;
  cmp_t             cmp;
  action_e          verdict;
  logic             emit_tick;

  assign accept   = start_i && !busy_o;
  assign peer_ext = CW'(peer_i);
  assign peer_ix  = IW'(peer_ext);
  assign peer_ok  = peer_ext < CW'(NODES);
  assign self_ext = CW'(self_q);
  assign first_ix = (self_ext == '0) ? IW'(1) : '0;

  // next index to visit, stepping over this node
  assign cand1     = CW'(idx_q) + CW'(1);
  assign cand2     = CW'(idx_q) + CW'(2);
  assign nxt       = (cand1 == self_ext) ? cand2 : cand1;
  assign tick_last = (cnt_q == CntW'(MaxOut - 1)) || (nxt >= CW'(NODES));

  always_comb begin
    unique case (state_q)
      S_AGE:   unit_base = origin_q;
      S_HEARD: unit_base = heard_q[idx_q];
      default: unit_base = sent_q[idx_q];
    endcase
  end

  pls_delta_unit u_delta (
    .now_i       (now_q),
    .base_i      (unit_base),
    .timeout_i   (to_q),
    .keepalive_i (ka_q),
    .cmp_o       (cmp)
  );

  // decision for the peer under idx_q, from the registered flags
  always_comb begin
    verdict = ACT_NONE;
    if (working_q[idx_q] == local_work_q) begin
      if (!local_work_q) begin
        if (linked_q[idx_q] || a_lt_to_q) begin
          if (h_gt_to_q && a_gt_to_q) begin
            verdict = ACT_UNLINK;
          end else if (s_gt_ka_q) begin
            verdict = ACT_KEEP;
          end
        end
      end else if (h_gt_to_q) begin
        verdict = ACT_UNLINK;
      end else if ((h_gt_ka_q || s_gt_ka_q) && is_main_q) begin
        verdict = ACT_KEEP_ACK;
      end
    end
  end

  // for each peer the last state first takes the sent delta, then the decision
  assign emit_tick = (state_q == S_SENT_JUDGE_PREP) && judge_phase_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept && cmd_i == CMD_TICK) begin
          state_d = S_AGE;
        end
      end
      S_AGE:   state_d = S_HEARD;
      S_HEARD: state_d = S_SENT_JUDGE_PREP;
      S_SENT_JUDGE_PREP: begin
        if (emit_tick) begin
          state_d = tick_last ? S_IDLE : S_HEARD;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign busy_o      = (state_q != S_IDLE);
  // hold writes off while a request is offered so both never land on one edge
  assign cfg_ready_o = !busy_o && !start_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      judge_phase_q <= 1'b0;
      idx_q         <= '0;
      cnt_q         <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == S_SENT_JUDGE_PREP) begin
        judge_phase_q <= !judge_phase_q;
      end else begin
        judge_phase_q <= 1'b0;
      end
      if (accept && cmd_i == CMD_TICK) begin
        idx_q <= first_ix;
        cnt_q <= '0;
      end else if (emit_tick && !tick_last) begin
        idx_q <= IW'(nxt);
        cnt_q <= cnt_q + CntW'(1);
      end
    end
  end

  // time and compare flags
  always_ff @(posedge clk_i) begin
    if (accept) begin
      now_q <= now_ms_i;
    end
    if (state_q == S_AGE) begin
      a_gt_to_q <= cmp.gt_to;
      a_lt_to_q <= cmp.lt_to;
    end
    if (state_q == S_HEARD) begin
      h_gt_to_q <= cmp.gt_to;
      h_gt_ka_q <= cmp.gt_ka;
    end
    if (state_q == S_SENT_JUDGE_PREP && !judge_phase_q) begin
      s_gt_ka_q <= cmp.gt_ka;
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      self_q <= '0;
      to_q   <= TimeoutRst;
      ka_q   <= KeepaliveRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_SELF:      self_q <= cfg_data_i[PeerW-1:0];
        CFG_TIMEOUT:   to_q   <= cfg_data_i[IntvW-1:0];
        CFG_KEEPALIVE: ka_q   <= cfg_data_i[IntvW-1:0];
        default:       ;
      endcase
    end
  end

  // peer table and local mode
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      linked_q     <= '0;
      working_q    <= '0;
      origin_q     <= '0;
      local_work_q <= 1'b0;
      is_main_q    <= 1'b1;
      for (int i = 0; i < NODES; i++) begin
        heard_q[i] <= '0;
        sent_q[i]  <= '0;
      end
    end else if (accept) begin
      unique case (cmd_i)
        CMD_HEARD: begin
          if (peer_ok) begin
            heard_q[peer_ix]  <= now_ms_i;
            linked_q[peer_ix] <= 1'b1;
          end
        end
        CMD_SENT: begin
          if (peer_ok) begin
            sent_q[peer_ix] <= now_ms_i;
          end
        end
        CMD_WORK: begin
          if (peer_ok) begin
            working_q[peer_ix] <= flag_value_i;
          end
        end
        CMD_MODE: begin
          local_work_q <= flag_value_i;
          is_main_q    <= main_role_i;
          if (restart_origin_i) begin
            origin_q <= now_ms_i;
          end
        end
        default: ;
      endcase
    end else if (emit_tick && verdict == ACT_UNLINK) begin
      linked_q[idx_q] <= 1'b0;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= (accept && cmd_i != CMD_TICK) || emit_tick;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_tick) begin
      res_peer_q <= PeerW'(idx_q);
      res_act_q  <= verdict;
      res_last_q <= tick_last;
    end else if (accept) begin
      res_act_q  <= ACT_NONE;
      res_last_q <= 1'b1;
      if (cmd_i == CMD_HEARD || cmd_i == CMD_SENT || cmd_i == CMD_WORK) begin
        res_peer_q <= peer_i;
      end else begin
        res_peer_q <= '0;
      end
    end
  end

  // linked flags of the first eight peers; linked_q already holds this result's update
  for (genvar g = 0; g < MaskW; g++) begin : g_mask
    if (g < NODES) begin : g_live
      assign linked_mask_o[g] = linked_q[g];
    end else begin : g_none
      assign linked_mask_o[g] = 1'b0;
    end
  end

  assign result_valid_o = res_valid_q;
  assign peer_out_o     = res_peer_q;
  assign action_o       = res_act_q;
  assign last_o         = res_last_q;

endmodule

[hdl/pls_checker.sv]
// Port-level checks for the peer link supervisor, bound to the top level.
module pls_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         start_i,
  input logic                         busy_o,
  input logic [pls_pkg::CmdW-1:0]     cmd_i,
  input logic                         cfg_ready_o,
  input logic                         result_valid_o,
  input logic [pls_pkg::ActW-1:0]     action_o,
  input logic                         last_o
);
  import pls_pkg::*;

  // a plain command answers in the next cycle with a single, empty result
  a_cmd_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && cmd_i != CMD_TICK
      |=> result_valid_o && last_o && action_o == ACT_NONE)
    else $error("plain command did not give one final empty result");

  a_tick_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && cmd_i == CMD_TICK |=> busy_o && !result_valid_o)
    else $error("tick did not hold the block busy");

  // busy must cover every result of a tick but the final one
  a_mid_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !last_o |-> busy_o)
    else $error("intermediate result shown while idle");

  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && last_o |-> !busy_o)
    else $error("block still busy at final result");

  // writes are open only while idle and no request is offered
  a_cfg_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready_o |-> !busy_o && !start_i)
    else $error("configuration open while a request is in progress");

endmodule

bind peer_link_supervisor_core pls_checker u_pls_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start_i        (start_i),
  .busy_o         (busy_o),
  .cmd_i          (cmd_i),
  .cfg_ready_o    (cfg_ready_o),
  .result_valid_o (result_valid_o),
  .action_o       (action_o),
  .last_o         (last_o)
);

[tb/sv/tb_peer_link_supervisor_core.sv]
// Self-checking testbench for the peer link supervisor: directed and random requests.

typedef struct packed {
  logic [pls_pkg::PeerW-1:0] peer;
  pls_pkg::action_e          act;
  logic [pls_pkg::MaskW-1:0] mask;
  logic                      last;
} verdict_t;

class supervisor_board;
  logic [pls_pkg::PeerW-1:0]    self_node;
  logic [pls_pkg::IntvW-1:0]    timeout_ms;
  logic [pls_pkg::IntvW-1:0]    keepalive_ms;
  logic [pls_pkg::NodesDef-1:0] linked;
  logic [pls_pkg::NodesDef-1:0] working;
  logic [pls_pkg::TimeW-1:0]    heard_at [pls_pkg::NodesDef];
  logic [pls_pkg::TimeW-1:0]    sent_at [pls_pkg::NodesDef];
  logic [pls_pkg::TimeW-1:0]    origin_ms;
  logic                         local_work;
  logic                         local_main;
  verdict_t                     due_verdicts [$];
  int                           errors;
  int                           reported;

  function new();
    self_node    = '0;
    timeout_ms   = pls_pkg::TimeoutRst;
    keepalive_ms = pls_pkg::KeepaliveRst;
    linked       = '0;
    working      = '0;
    origin_ms    = '0;
    local_work   = 1'b0;
    local_main   = 1'b1;
    foreach (heard_at[i]) begin
      heard_at[i] = '0;
      sent_at[i]  = '0;
    end
    errors   = 0;
    reported = 0;
  endfunction

  function void set_register(pls_pkg::cfg_idx_e idx, logic [pls_pkg::CfgDataW-1:0] data);
    case (idx)
      pls_pkg::CFG_SELF:      self_node = data[pls_pkg::PeerW-1:0];
      pls_pkg::CFG_TIMEOUT:   timeout_ms = data;
      pls_pkg::CFG_KEEPALIVE: keepalive_ms = data;
      default: ;
    endcase
  endfunction

  // Decide one peer on a tick; may clear its linked flag.
  function pls_pkg::action_e peer_verdict(int p, logic [pls_pkg::TimeW-1:0] now);
    logic [pls_pkg::TimeW-1:0] age;
    logic [pls_pkg::TimeW-1:0] quiet;
    logic [pls_pkg::TimeW-1:0] since_sent;
    age        = now - origin_ms;
    quiet      = now - heard_at[p];
    since_sent = now - sent_at[p];
    if (working[p] != local_work) return pls_pkg::ACT_NONE;
    if (!local_work) begin
      if (linked[p] || age < timeout_ms) begin
        if (quiet > timeout_ms && age > timeout_ms) begin
          linked[p] = 1'b0;
          return pls_pkg::ACT_UNLINK;
        end
        if (since_sent > keepalive_ms) return pls_pkg::ACT_KEEP;
      end
      return pls_pkg::ACT_NONE;
    end
    if (quiet > timeout_ms) begin
      linked[p] = 1'b0;
      return pls_pkg::ACT_UNLINK;
    end
    if ((quiet > keepalive_ms || since_sent > keepalive_ms) && local_main)
      return pls_pkg::ACT_KEEP_ACK;
    return pls_pkg::ACT_NONE;
  endfunction

  function void note_request(logic [pls_pkg::CmdW-1:0] cmd, logic [pls_pkg::TimeW-1:0] now,
                             logic [pls_pkg::PeerW-1:0] peer, logic flag, logic role,
                             logic restart);
    verdict_t v;
    int       last_p;
    if (cmd == pls_pkg::CMD_TICK) begin
      last_p = (self_node == pls_pkg::NodesDef - 1) ? pls_pkg::NodesDef - 2
                                                    : pls_pkg::NodesDef - 1;
      for (int i = 0; i < pls_pkg::NodesDef; i++) begin
        if (i != self_node) begin
          v.act  = peer_verdict(i, now);
          v.peer = 3'(i);
          v.mask = linked;
          v.last = (i == last_p);
          due_verdicts.push_back(v);
        end
      end
      return;
    end
    case (cmd)
      pls_pkg::CMD_HEARD: begin
        heard_at[peer] = now;
        linked[peer]   = 1'b1;
      end
      pls_pkg::CMD_SENT: sent_at[peer] = now;
      pls_pkg::CMD_WORK: working[peer] = flag;
      pls_pkg::CMD_MODE: begin
        local_work = flag;
        local_main = role;
        if (restart) origin_ms = now;
      end
      default: ;
    endcase
    v.peer = (cmd >= pls_pkg::CMD_MODE) ? '0 : peer;
    v.act  = pls_pkg::ACT_NONE;
    v.mask = linked;
    v.last = 1'b1;
    due_verdicts.push_back(v);
  endfunction

  function void check_result(logic [pls_pkg::PeerW-1:0] peer, logic [pls_pkg::ActW-1:0] act,
                             logic [pls_pkg::MaskW-1:0] mask, logic last);
    verdict_t want;
    if (due_verdicts.size() == 0) begin
      errors++;
      if (reported < 10)
        $display("unexpected result: peer %0d action %0d mask %02h last %0d",
                 peer, act, mask, last);
      reported++;
      return;
    end
    want = due_verdicts.pop_front();
    if (want.peer !== peer || want.act !== act || want.mask !== mask || want.last !== last)
    begin
      errors++;
      if (reported < 10)
        $display("mismatch: exp p%0d a%0d m%02h l%0d, got p%0d a%0d m%02h l%0d",
                 want.peer, want.act, want.mask, want.last, peer, act, mask, last);
      reported++;
    end
  endfunction
endclass

module tb_peer_link_supervisor_core;
  timeunit 1ns;
  timeprecision 1ps;

  import pls_pkg::*;

  localparam int StallLimit = 3000;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                start_i;
  logic                busy_o;
  logic [CmdW-1:0]     cmd_i;
  logic [TimeW-1:0]    now_ms_i;
  logic [PeerW-1:0]    peer_i;
  logic                flag_value_i;
  logic                main_role_i;
  logic                restart_origin_i;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;
  logic                result_valid_o;
  logic [PeerW-1:0]    peer_out_o;
  logic [ActW-1:0]     action_o;
  logic [MaskW-1:0]    linked_mask_o;
  logic                last_o;

  supervisor_board board;
  logic [TimeW-1:0] wall_ms;
  logic             mode_flag;
  logic             steady;

  peer_link_supervisor_core #(
    .NODES(NodesDef)
  ) i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start_i),
    .busy_o          (busy_o),
    .cmd_i           (cmd_i),
    .now_ms_i        (now_ms_i),
    .peer_i          (peer_i),
    .flag_value_i    (flag_value_i),
    .main_role_i     (main_role_i),
    .restart_origin_i(restart_origin_i),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .result_valid_o  (result_valid_o),
    .peer_out_o      (peer_out_o),
    .action_o        (action_o),
    .linked_mask_o   (linked_mask_o),
    .last_o          (last_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o)
      board.check_result(peer_out_o, action_o, linked_mask_o, last_o);
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic issue_request(input logic [CmdW-1:0] cmd, input logic [TimeW-1:0] now,
                               input logic [PeerW-1:0] peer, input logic flag,
                               input logic role, input logic restart);
    int gap;
    gap              = pick_gap();
    start_i          = 1'b1;
    cmd_i            = cmd;
    now_ms_i         = now;
    peer_i           = peer;
    flag_value_i     = flag;
    main_role_i      = role;
    restart_origin_i = restart;
    do @(posedge clk_i); while (busy_o);
    board.note_request(cmd, now, peer, flag, role, restart);
    @(negedge clk_i);
    // keep start high when the next request follows at once
    if (gap > 0) begin
      start_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
  endtask

  task automatic stop_and_drain(input int settle);
    start_i = 1'b0;
    while (board.due_verdicts.size() != 0) @(negedge clk_i);
    repeat (settle) @(negedge clk_i);
  endtask

  task automatic write_settings(input logic [PeerW-1:0] self_idx, input logic [IntvW-1:0] to,
                                input logic [IntvW-1:0] ka);
    cfg_idx_e            order [3] = '{CFG_SELF, CFG_TIMEOUT, CFG_KEEPALIVE};
    logic [CfgDataW-1:0] vals [3];
    vals[0] = CfgDataW'(self_idx);
    vals[1] = to;
    vals[2] = ka;
    for (int k = 0; k < 3; k++) begin
      cfg_valid_i = 1'b1;
      cfg_index_i = order[k];
      cfg_data_i  = vals[k];
      do @(posedge clk_i); while (!cfg_ready_o);
      board.set_register(order[k], vals[k]);
      @(negedge clk_i);
    end
    cfg_valid_i = 1'b0;
  endtask

  task automatic random_phase(input int count);
    int unsigned      span;
    int unsigned      step;
    int               pick;
    logic [PeerW-1:0] who;
    logic             wflag;
    span = (board.timeout_ms == 0) ? 8 : board.timeout_ms;
    repeat (count) begin
      // advance wall time mostly within the timeout, sometimes far past it
      pick = $urandom_range(0, 99);
      if (pick < 70) step = $urandom_range(0, span / 2);
      else if (pick < 94) step = $urandom_range(span / 2, span * 2);
      else step = $urandom;
      wall_ms = wall_ms + step;
      who     = 3'($urandom_range(0, 7));
      pick    = $urandom_range(0, 99);
      if (pick < 35) begin
        issue_request(CMD_TICK, wall_ms, who, 1'($urandom), 1'($urandom), 1'($urandom));
      end else if (pick < 60) begin
        issue_request(CMD_HEARD, wall_ms, who, 1'($urandom), 1'($urandom), 1'($urandom));
      end else if (pick < 72) begin
        issue_request(CMD_SENT, wall_ms, who, 1'($urandom), 1'($urandom), 1'($urandom));
      end else if (pick < 82) begin
        wflag = ($urandom_range(0, 3) != 0) ? mode_flag : ~mode_flag;
        issue_request(CMD_WORK, wall_ms, who, wflag, 1'($urandom), 1'($urandom));
      end else if (pick < 93) begin
        if ($urandom_range(0, 1) == 1) mode_flag = ~mode_flag;
        issue_request(CMD_MODE, wall_ms, who, mode_flag, $urandom_range(0, 4) != 0,
                      1'($urandom));
      end else begin
        issue_request(3'($urandom_range(5, 7)), wall_ms, who, 1'($urandom), 1'($urandom),
                      1'($urandom));
      end
    end
  endtask

  initial begin
    logic [IntvW-1:0] to;
    board            = new();
    rst_ni           = 1'b0;
    start_i          = 1'b0;
    cmd_i            = CMD_TICK;
    now_ms_i         = '0;
    peer_i           = '0;
    flag_value_i     = 1'b0;
    main_role_i      = 1'b0;
    restart_origin_i = 1'b0;
    cfg_valid_i      = 1'b0;
    cfg_index_i      = CFG_SELF;
    cfg_data_i       = '0;
    wall_ms          = '0;
    mode_flag        = 1'b0;
    steady           = 1'b0;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // reset settings: idle local node, main role, origin at zero
    issue_request(CMD_TICK,  32'd0,        3'd0, 1'b0, 1'b0, 1'b0);
    issue_request(CMD_HEARD, 32'd100,      3'd7, 1'b0, 1'b0, 1'b0);
    issue_request(CMD_HEARD, 32'd100,      3'd0, 1'b1, 1'b1, 1'b1);
    issue_request(CMD_SENT,  32'hFFFFFFFF, 3'd3, 1'b0, 1'b0, 1'b0);
    issue_request(CMD_TICK,  32'd3000,     3'd0, 1'b0, 1'b0, 1'b0);
    issue_request(CMD_TICK,  32'd9000,     3'd0, 1'b0, 1'b0, 1'b0);
    issue_request(3'd5,      32'hFFFFFFFF, 3'd7, 1'b1, 1'b1, 1'b1);
    issue_request(3'd6,      32'h12345678, 3'd5, 1'b1, 1'b0, 1'b1);
    issue_request(3'd7,      32'h0,        3'd2, 1'b0, 1'b1, 1'b1);
    // working mode: peers 2 and 5 join, peer 5 stays silent
    issue_request(CMD_WORK,  32'd9500,     3'd2, 1'b1, 1'b0, 1'b0);
    issue_request(CMD_WORK,  32'd9500,     3'd5, 1'b1, 1'b0, 1'b0);
    issue_request(CMD_MODE,  32'd10000,    3'd6, 1'b1, 1'b1, 1'b1);
    issue_request(CMD_HEARD, 32'd10000,    3'd2, 1'b0, 1'b0, 1'b0);
    issue_request(CMD_TICK,  32'd12500,    3'd0, 1'b0, 1'b0, 1'b0);
    issue_request(CMD_MODE,  32'd12500,    3'd1, 1'b1, 1'b0, 1'b0);
    issue_request(CMD_TICK,  32'd12600,    3'd0, 1'b0, 1'b0, 1'b0);
    // origin and stamps just below the wrap point
    issue_request(CMD_MODE,  32'hFFFFFF00, 3'd0, 1'b0, 1'b1, 1'b1);
    issue_request(CMD_HEARD, 32'hFFFFFFF0, 3'd4, 1'b0, 1'b0, 1'b0);
    issue_request(CMD_SENT,  32'hFFFFFFF0, 3'd4, 1'b0, 1'b0, 1'b0);
    issue_request(CMD_TICK,  32'h00000100, 3'd0, 1'b0, 1'b0, 1'b0);
    issue_request(CMD_TICK,  32'h7FFFFFFF, 3'd0, 1'b0, 1'b0, 1'b0);
    issue_request(CMD_WORK,  32'h80000000, 3'd2, 1'b0, 1'b0, 1'b0);
    issue_request(CMD_WORK,  32'h80000000, 3'd5, 1'b0, 1'b0, 1'b0);
    stop_and_drain(4);

    wall_ms = $urandom;
    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        0: write_settings(3'd7, 16'hFFFF, 16'hFFFF);
        1: write_settings(3'd0, 16'd1, 16'd1);
        2: write_settings(3'd3, 16'd0, 16'd0);
        default: begin
          to = 16'($urandom_range(20, 3000));
          write_settings(3'($urandom_range(0, 7)), to, 16'($urandom_range(5, to)));
        end
      endcase
      steady = ($urandom_range(0, 2) == 0);
      random_phase(22);
      stop_and_drain(4);
    end

    stop_and_drain(30);
    if (board.due_verdicts.size() != 0) begin
      $display("%0d expected results never arrived", board.due_verdicts.size());
      board.errors++;
    end
    if (board.errors == 0) begin
      $display("tb_peer_link_supervisor_core: PASS");
    end else begin
      $display("tb_peer_link_supervisor_core: FAIL");
    end
    $finish;
  end

  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < StallLimit) begin
      @(posedge clk_i);
      if ((start_i && !busy_o) || result_valid_o || (cfg_valid_i && cfg_ready_o))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("tb_peer_link_supervisor_core: FAIL");
    $finish;
  end

endmodule
